FILE: src/assert_macros.svh
// Assertion macros for the RTL of the frame checker.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define AFC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame checker assertion failed");

// next-cycle implication
`define AFC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame checker assertion failed");

`else

`define AFC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AFC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: src/afc_pkg.sv
// Types, codes and small arithmetic helpers of the frame checker.
// No dependencies; used by the interfaces and the core.
package afc_pkg;

    localparam int BYTE_W     = 8;
    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_FIELDS = 5;
    localparam int NUM_SUM    = 4;   // fields that feed the checksum

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

    localparam logic [BYTE_W-1:0] EXP_SENDER_RST = 8'd90;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CSUM_BAD  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRONG_ADR = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRONG_SND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FIELD_CNT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_TERM  = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_SND  = 2'd1;

    // reciprocals: exact floor division of any 32-bit unsigned value
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;  // >> 35
    localparam logic [31:0] RECIP_9  = 32'h38E3_8E39;  // >> 33

    typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] t_fields;
    typedef logic [NUM_SUM-1:0][FIELD_W-1:0]    t_sum_words;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                chk;     // address checks passed, checksum decides
        logic [NUM_SUM-1:0]  neg;     // sign of fields 0..3
        t_fields             fields;
    } t_frame;

    // a / 10, or a / 9 when by9
    function automatic logic [31:0] div_small(input logic [31:0] a, input logic by9);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, (by9 ? RECIP_9 : RECIP_10)};
        return by9 ? {1'b0, p[63:33]} : {3'b000, p[63:35]};
    endfunction

    // q * 10, or q * 9 when by9
    function automatic logic [31:0] mul_small(input logic [31:0] q, input logic by9);
        return by9 ? ((q << 3) + q) : ((q << 3) + (q << 1));
    endfunction

endpackage

FILE: src/afc_ifs.sv
// Handshake interfaces of the frame checker: received bytes, results, register writes.
// Depends on afc_pkg.
interface afc_byte_if;
    import afc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afc_result_if;
    import afc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [FIELD_W-1:0]  field_a;
    logic signed [FIELD_W-1:0]  field_b;
    logic signed [FIELD_W-1:0]  field_c;
    logic signed [FIELD_W-1:0]  field_d;
    logic signed [FIELD_W-1:0]  field_e;
    modport source (output valid, output status, output field_a, output field_b,
                    output field_c, output field_d, output field_e, input ready);
    modport sink   (input valid, input status, input field_a, input field_b,
                    input field_c, input field_d, input field_e, output ready);
endinterface

interface afc_cfg_if;
    import afc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [BYTE_W-1:0]    wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: src/ascii_frame_checker_core.sv
// Frame checker core: parses "f0:f1:f2:f3:f4/t" byte streams and reports one status per frame.
// Depends on afc_pkg, afc_ifs.sv and assert_macros.svh.

// One received byte is taken per clock cycle while no closing byte waits. Field, colon and slash
// state is updated in the cycle a byte is accepted; the byte after '/' closes the frame and its
// result passes through r_f1 to r_f4 and the output register r_out, a short pipeline that
// computes the digit-mix checksum (two reciprocal-multiply stages per field). Results queue
// in the pipeline while the result sink stalls; bytes inside a frame are always taken, and a
// closing byte waits only when every pipeline stage is full. Register writes are taken at once
// and apply to the frames that close afterwards; write them only while no frame is in flight.
`include "assert_macros.svh"

module ascii_frame_checker_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    afc_byte_if.sink         i_rx,
    afc_cfg_if.sink          i_cfg,
    afc_result_if.source     o_res
);
    import afc_pkg::*;

    // configuration
    logic [BYTE_W-1:0] r_own_addr;
    logic [BYTE_W-1:0] r_exp_snd;

    // parse state
    t_fields     r_acc, n_acc;
    logic [2:0]  r_colons, n_colons;
    logic        r_slash, n_slash;

    // pipeline
    logic        r_v1, r_v2, r_v3, r_v4, r_vo;
    logic        en1, en2, en3, en4, en_o;
    t_frame      r_f1, r_f2, r_f3, r_f4, n_f1;
    t_sum_words  r_mag1, r_mag2, r_q2, r_s3, r_s4, r_q4, n_mag1;
    t_frame      r_out, n_out;

    logic        rx_acc;
    logic        is_close;

    assign en_o = !r_vo || o_res.ready;
    assign en4  = !r_v4 || en_o;
    assign en3  = !r_v3 || en4;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;

    assign i_rx.ready = !r_slash || en1;
    assign rx_acc     = i_rx.valid && i_rx.ready;
    assign is_close   = rx_acc && r_slash;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= '0;
            r_exp_snd  <= EXP_SENDER_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_OWN_ADDR: r_own_addr <= i_cfg.wr_data;
                REG_EXP_SND:  r_exp_snd  <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // byte parser
    always_comb begin
        n_acc    = r_acc;
        n_colons = r_colons;
        n_slash  = r_slash;
        if (rx_acc) begin
            if (r_slash) begin
                n_acc    = '0;
                n_colons = '0;
                n_slash  = 1'b0;
            end else if (i_rx.rx_byte == CH_SLASH) begin
                n_slash = 1'b1;
            end else if (i_rx.rx_byte == CH_COLON) begin
                if (r_colons != 3'd7) n_colons = r_colons + 3'd1;
            end else begin
                // bytes past the fifth field fall through every compare
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    if (r_colons == 3'(k))
                        n_acc[k] = (r_acc[k] << 3) + (r_acc[k] << 1)
                                 + {24'd0, i_rx.rx_byte} - {24'd0, CH_ZERO};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_colons <= '0;
            r_slash  <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_colons <= n_colons;
            r_slash  <= n_slash;
        end
    end

    // frame close: early checks, magnitudes for the checksum
    always_comb begin
        n_f1.chk    = 1'b0;
        n_f1.fields = r_acc;
        if (i_rx.rx_byte != CH_T) begin
            n_f1.status = ST_BAD_TERM;
            n_f1.fields = '0;
        end else if (r_colons != 3'd4) begin
            n_f1.status = ST_FIELD_CNT;
        end else if (r_acc[0] != {24'd0, r_exp_snd}) begin
            n_f1.status = ST_WRONG_SND;
        end else if (r_acc[1] != {24'd0, r_own_addr}) begin
            n_f1.status = ST_WRONG_ADR;
        end else begin
            n_f1.status = ST_OK;
            n_f1.chk    = 1'b1;
        end
        for (int k = 0; k < NUM_SUM; k++) begin
            n_f1.neg[k] = r_acc[k][FIELD_W-1];
            n_mag1[k]   = r_acc[k][FIELD_W-1] ? (32'd0 - r_acc[k]) : r_acc[k];
        end
    end

    // checksum tail and final status
    always_comb begin
        logic [3:0]         d;
        logic signed [10:0] sd [NUM_SUM];
        logic signed [10:0] t;
        logic signed [10:0] cs;
        logic [10:0]        tm;
        logic [10:0]        rem;
        for (int k = 0; k < NUM_SUM; k++) begin
            d     = 4'(r_s4[k] - mul_small(r_q4[k], k[0]));
            sd[k] = r_f4.neg[k] ? -$signed({7'd0, d}) : $signed({7'd0, d});
        end
        t   = (sd[0] * 11'sd10 + sd[1]) + 11'sd2 * (sd[2] * 11'sd10 + sd[3]);
        tm  = t[10] ? 11'(-t) : 11'(t);
        if (tm >= 11'd200)      rem = tm - 11'd200;
        else if (tm >= 11'd100) rem = tm - 11'd100;
        else                    rem = tm;
        cs  = t[10] ? -$signed(rem) : $signed(rem);
        n_out = r_f4;
        if (r_f4.chk)
            n_out.status = ($signed(r_f4.fields[4]) == $signed({{21{cs[10]}}, cs}))
                         ? ST_OK : ST_CSUM_BAD;
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)  r_v1 <= is_close;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en4)  r_v4 <= r_v3;
            if (en_o) r_vo <= r_v4;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_f1   <= n_f1;
            r_mag1 <= n_mag1;
        end
        if (en2) begin
            r_f2   <= r_f1;
            r_mag2 <= r_mag1;
            for (int k = 0; k < NUM_SUM; k++)
                r_q2[k] <= div_small(r_mag1[k], k[0]);
        end
        if (en3) begin
            r_f3 <= r_f2;
            // remainder plus quotient
            for (int k = 0; k < NUM_SUM; k++)
                r_s3[k] <= r_q2[k] + (r_mag2[k] - mul_small(r_q2[k], k[0]));
        end
        if (en4) begin
            r_f4 <= r_f3;
            r_s4 <= r_s3;
            for (int k = 0; k < NUM_SUM; k++)
                r_q4[k] <= div_small(r_s3[k], k[0]);
        end
        if (en_o) r_out <= n_out;
    end

    assign o_res.valid   = r_vo;
    assign o_res.status  = r_out.status;
    assign o_res.field_a = $signed(r_out.fields[0]);
    assign o_res.field_b = $signed(r_out.fields[1]);
    assign o_res.field_c = $signed(r_out.fields[2]);
    assign o_res.field_d = $signed(r_out.fields[3]);
    assign o_res.field_e = $signed(r_out.fields[4]);

    `AFC_ASSERT_NXT(a_close_clears, i_clk, i_rst_n, is_close, (!r_slash && r_colons == 3'd0))
    `AFC_ASSERT_NXT(a_stage_moves, i_clk, i_rst_n, (r_v1 && en2), r_v2)
    `AFC_ASSERT_IMP(a_term_zero, i_clk, i_rst_n, (r_vo && r_out.status == ST_BAD_TERM), (r_out.fields == '0))
    `AFC_ASSERT_IMP(a_chk_only_ok, i_clk, i_rst_n, (r_v4 && r_f4.chk), (r_f4.status == ST_OK))

endmodule

FILE: tb/ascii_frame_checker_core_tb.sv
// Self-checking testbench for ascii_frame_checker_core: frames in on the byte channel, one
// status report per closed frame out, compared against an in-bench parser model.
// Depends on afc_pkg, afc_ifs.sv and the core.
`timescale 1ns / 1ps

module ascii_frame_checker_core_tb;
    import afc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 280;
    localparam int NUM_PHASES   = 6;

    // register slots the block does not implement; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]                   status;
        logic [NUM_FIELDS-1:0][FIELD_W-1:0]    fields;
    } t_frame_report;

    logic i_clk;
    logic i_rst_n;

    afc_byte_if   rx_if ();
    afc_cfg_if    cfg_if ();
    afc_result_if res_if ();

    ascii_frame_checker_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // parser model state
    logic [FIELD_W-1:0] acc [NUM_FIELDS];
    logic [2:0]         colon_cnt;
    logic               slash_seen;
    logic [BYTE_W-1:0]  own_addr;
    logic [BYTE_W-1:0]  exp_sender;

    logic [BYTE_W-1:0] rx_bytes_q [$];
    t_frame_report     frame_reports_q [$];

    int  rx_pushed;
    int  rx_taken;
    int  reports_seen;
    int  cfg_writes;
    int  errors;
    int  stall_cycles;
    int  rx_gap;
    int  rdy_gap;
    int  phase_bytes;
    int  status_seen [8];
    bit  quiet;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int digit_mix(input int x, input int m);
        int r;
        r = x % m;
        return (r + (x - r) / m) % m;
    endfunction

    function automatic int frame_checksum(input logic [FIELD_W-1:0] f0, input logic [FIELD_W-1:0] f1,
                                          input logic [FIELD_W-1:0] f2, input logic [FIELD_W-1:0] f3);
        int d1, d2, d3, d4;
        d1 = digit_mix($signed(f0), 10);
        d2 = digit_mix($signed(f1), 9);
        d3 = digit_mix($signed(f2), 10);
        d4 = digit_mix($signed(f3), 9);
        return ((d1 * 10 + d2) + 2 * (d3 * 10 + d4)) % 100;
    endfunction

    function automatic void clear_parse();
        int k;
        for (k = 0; k < NUM_FIELDS; k++) acc[k] = '0;
        colon_cnt  = '0;
        slash_seen = 1'b0;
    endfunction

    // advance the model by one accepted byte; a closing byte queues a report
    function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
        t_frame_report rep;
        int            k;
        if (!slash_seen) begin
            if (b == CH_SLASH) begin
                slash_seen = 1'b1;
            end else if (b == CH_COLON) begin
                if (colon_cnt < 3'd7) colon_cnt = colon_cnt + 3'd1;
            end else if (colon_cnt < 3'(NUM_FIELDS)) begin
                acc[colon_cnt] = acc[colon_cnt] * 32'd10 + {24'd0, b} - {24'd0, CH_ZERO};
            end
            return;
        end
        rep.fields = '0;
        if (b != CH_T) begin
            rep.status = ST_BAD_TERM;
        end else begin
            for (k = 0; k < NUM_FIELDS; k++) rep.fields[k] = acc[k];
            if (colon_cnt != 3'(NUM_FIELDS - 1))
                rep.status = ST_FIELD_CNT;
            else if (acc[0] != {24'd0, exp_sender})
                rep.status = ST_WRONG_SND;
            else if (acc[1] != {24'd0, own_addr})
                rep.status = ST_WRONG_ADR;
            else if (frame_checksum(acc[0], acc[1], acc[2], acc[3]) != $signed(acc[4]))
                rep.status = ST_CSUM_BAD;
            else
                rep.status = ST_OK;
        end
        frame_reports_q.push_back(rep);
        clear_parse();
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ---------------- stimulus helpers ----------------
    task automatic push_rx(input logic [BYTE_W-1:0] b);
        rx_bytes_q.push_back(b);
        rx_pushed++;
        phase_bytes++;
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_rx(s[i]);
    endtask

    task automatic push_dec(input int unsigned v);
        string s;
        if (v == 0 && $urandom_range(0, 2) == 0) return;   // empty field parses as zero
        if ($urandom_range(0, 9) == 0) push_rx(CH_ZERO);
        s = $sformatf("%0d", v);
        push_str(s);
    endtask

    task automatic push_digits(input int n);
        int i;
        for (i = 0; i < n; i++) push_rx(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // mostly digits, some arbitrary bytes; long runs wrap the accumulator
    task automatic push_junk_field();
        int               n, i;
        logic [BYTE_W-1:0] b;
        n = $urandom_range(0, 14);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                b = CH_ZERO + 8'($urandom_range(0, 9));
            end else begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_COLON || b == CH_SLASH);
            end
            push_rx(b);
        end
    endtask

    function automatic int unsigned rand_field_value();
        case ($urandom_range(0, 9))
            7, 8:    return $urandom_range(0, 99999);
            9:       return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(0, 99);
        endcase
    endfunction

    task automatic gen_frame();
        int unsigned      f [NUM_FIELDS];
        int               kind, cs, ncol, i;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            f[0] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : exp_sender;
            f[1] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : own_addr;
            f[2] = rand_field_value();
            f[3] = rand_field_value();
            cs   = frame_checksum(f[0], f[1], f[2], f[3]);
            f[4] = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 99) : cs;
            for (i = 0; i < NUM_FIELDS; i++) begin
                if (i != 0) push_rx(CH_COLON);
                push_dec(f[i]);
            end
            push_rx(CH_SLASH);
            if (kind < 60) begin
                push_rx(CH_T);
            end else begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_T);
                push_rx(b);
            end
        end else if (kind < 82) begin
            do ncol = $urandom_range(0, 7); while (ncol == NUM_FIELDS - 1);
            push_digits($urandom_range(0, 4));
            for (i = 0; i < ncol; i++) begin
                push_rx(CH_COLON);
                push_digits($urandom_range(0, 4));
            end
            push_rx(CH_SLASH);
            push_rx(CH_T);
        end else if (kind < 92) begin
            for (i = 0; i < NUM_FIELDS; i++) begin
                if (i != 0) push_rx(CH_COLON);
                push_junk_field();
            end
            push_rx(CH_SLASH);
            push_rx(CH_T);
        end else begin
            // raw noise, may leave a partial frame behind
            ncol = $urandom_range(1, 12);
            for (i = 0; i < ncol; i++) push_rx(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_OWN_ADDR: own_addr   = data;
            REG_EXP_SND:  exp_sender = data;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (rx_taken != rx_pushed || frame_reports_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- byte driver ----------------
    always @(posedge i_clk) begin : rx_driver
        logic              nv;
        logic [BYTE_W-1:0] nb;
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            nv = rx_if.valid;
            nb = rx_if.rx_byte;
            if (rx_if.valid && rx_if.ready) begin
                parse_rx_byte(rx_if.rx_byte);
                rx_taken++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                end else if (rx_bytes_q.size() != 0) begin
                    if (!quiet && $urandom_range(0, 15) == 0) begin
                        rx_gap = $urandom_range(0, 15);
                    end else begin
                        nv = 1'b1;
                        nb = rx_bytes_q.pop_front();
                    end
                end
            end
            rx_if.valid   <= nv;
            rx_if.rx_byte <= nb;
        end
    end

    // ---------------- report monitor ----------------
    always @(posedge i_clk) begin : report_monitor
        t_frame_report      rep;
        logic [FIELD_W-1:0] act [NUM_FIELDS];
        logic              nr;
        int                k;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                reports_seen++;
                status_seen[res_if.status]++;
                act[0] = res_if.field_a;
                act[1] = res_if.field_b;
                act[2] = res_if.field_c;
                act[3] = res_if.field_d;
                act[4] = res_if.field_e;
                if (frame_reports_q.size() == 0) begin
                    note_error($sformatf("report %0d with nothing pending, status %0d",
                                         reports_seen, res_if.status));
                end else begin
                    rep = frame_reports_q.pop_front();
                    if (rep.status !== res_if.status)
                        note_error($sformatf("report %0d status: expected %0d, got %0d",
                                             reports_seen, rep.status, res_if.status));
                    for (k = 0; k < NUM_FIELDS; k++) begin
                        if (rep.fields[k] !== act[k])
                            note_error($sformatf("report %0d field %0d: expected %0d, got %0d",
                                                 reports_seen, k, $signed(rep.fields[k]),
                                                 $signed(act[k])));
                    end
                end
            end
            nr = 1'b1;
            if (rdy_gap > 0) begin
                rdy_gap--;
                nr = 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                rdy_gap = $urandom_range(0, 15);
                nr = 1'b0;
            end
            res_if.ready <= nr;
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles, %0d reports pending",
                 STALL_LIMIT, frame_reports_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // ---------------- sequence ----------------
    initial begin : main_seq
        int p;
        i_rst_n          = 1'b0;
        rx_if.valid      = 1'b0;
        rx_if.rx_byte    = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wr_data   = '0;
        res_if.ready     = 1'b0;
        rx_pushed = 0; rx_taken = 0; reports_seen = 0; cfg_writes = 0; errors = 0;
        rx_gap = 0; rdy_gap = 0; quiet = 1'b0;
        for (p = 0; p < 8; p++) status_seen[p] = 0;
        own_addr   = '0;
        exp_sender = EXP_SENDER_RST;
        clear_parse();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under reset settings
        push_str("90:0:::90/t");               // good frame
        push_str("90:0:::91/t");               // checksum off by one
        push_str("90:7:::90/t");               // not our address
        push_str("91:0:::90/t");               // foreign sender
        push_str("90:0:1/t");                  // too few fields
        push_str("1:2:3:4:5:6:7:8:9/t");       // colon count saturates, tail ignored
        push_str("90:0:::90/");
        push_rx(8'hFF);                        // bad terminator
        push_str("//");                        // slash after slash closes the frame
        push_rx(8'h00);
        push_rx(8'hFF);
        push_str(":0:::0/t");                  // extreme byte values as field content
        push_str("99999999999:0:::0/t");       // accumulator wraps
        push_str("/t");                        // empty frame
        wait_idle();

        for (p = 1; p <= NUM_PHASES; p++) begin
            case (p)
                1: begin write_reg(REG_OWN_ADDR, 8'd255); write_reg(REG_EXP_SND, 8'd0);   end
                2: begin write_reg(REG_OWN_ADDR, 8'd0);   write_reg(REG_EXP_SND, 8'd255); end
                3: begin
                    write_reg(REG_SPARE_2, 8'($urandom_range(0, 255)));
                    write_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
                    write_reg(REG_OWN_ADDR, 8'd255);
                    write_reg(REG_EXP_SND, 8'd255);
                end
                5: begin
                    write_reg(REG_OWN_ADDR, 8'($urandom_range(0, 255)));
                    write_reg(REG_EXP_SND, EXP_SENDER_RST);
                end
                default: begin
                    write_reg(REG_OWN_ADDR, 8'($urandom_range(0, 255)));
                    write_reg(REG_EXP_SND, 8'($urandom_range(0, 255)));
                end
            endcase
            if (p == NUM_PHASES) quiet = 1'b1;   // closing stretch at full rate
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) gen_frame();
            wait_idle();
        end

        if (frame_reports_q.size() != 0)
            note_error($sformatf("%0d reports never arrived", frame_reports_q.size()));

        $display("Run covered %0d bytes, %0d frame reports and %0d register writes",
                 rx_taken, reports_seen, cfg_writes);
        $display("Statuses: ok %0d, checksum %0d, address %0d, sender %0d, count %0d, term %0d",
                 status_seen[ST_OK], status_seen[ST_CSUM_BAD], status_seen[ST_WRONG_ADR],
                 status_seen[ST_WRONG_SND], status_seen[ST_FIELD_CNT], status_seen[ST_BAD_TERM]);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
